@@ rtl/core/epoch_seconds_to_datetime_defines.svh @@
// assertion macros for the epoch seconds to datetime block
`ifndef EPOCH_SECONDS_TO_DATETIME_DEFINES_SVH
`define EPOCH_SECONDS_TO_DATETIME_DEFINES_SVH

// condition must never hold at a clock edge
`define ES2DT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ES2DT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ES2DT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/es2dt_pkg.sv @@
package es2dt_pkg;

    // valid input window, 0001-01-01 00:00:00 .. 9999-12-31 23:59:59
    localparam logic signed [38:0] TS_MIN = -39'sd62135596800;
    localparam logic signed [38:0] TS_MAX = 39'sd253402300799;
    // seconds from 0001-01-01 to the epoch, a whole number of days
    localparam logic [38:0] TS_OFS = 39'd62135596800;

    // register stages in the back pipeline
    localparam int BACK_LAT = 12;

    // seconds per day is 675 << 7
    localparam logic [9:0]  SPD_HI     = 10'd675;
    localparam logic [31:0] RCP_675    = 32'((64'd1 << 41) / 64'd675);
    // day count from 0001-01-01 to the shifted julian day used below
    localparam logic [22:0] JDN_BIAS   = 23'd1753470;

    // exact reciprocals, rounded up
    localparam logic [17:0] RCP_60S    = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
    localparam logic [11:0] RCP_60M    = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
    localparam logic [25:0] RCP_146097 = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
    localparam logic [20:0] RCP_1461   = 21'(((64'd1 << 30) + 64'd1460) / 64'd1461);
    localparam logic [11:0] RCP_153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [11:0] RCP_5      = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

    localparam logic [17:0] C_146097   = 18'd146097;
    localparam logic [10:0] C_1461     = 11'd1461;
    localparam logic [7:0]  C_153      = 8'd153;
    localparam logic [15:0] YEAR_BIAS  = 16'd4800;

    typedef struct packed {
        logic        oor;
        logic [38:0] ofs;   // seconds since 0001-01-01, zero when out of range
    } es2dt_item_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        oor;
    } es2dt_result_t;

endpackage

@@ rtl/core/epoch_seconds_to_datetime.sv @@
// path: each accepted beat passes the front register, the mid queue, the back pipeline
// and the result queue before it shows on the result ports
// throughput: one beat per cycle, sustained while RESULT_DEPTH >= BACK_LAT + 2 and results are popped as they come
// reset: rst_n low empties both queues, clears the pipeline valid bits and the in-flight count; no other state
`include "epoch_seconds_to_datetime_defines.svh"
module epoch_seconds_to_datetime
    import es2dt_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 4,
    parameter int RESULT_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [38:0] timestamp,
    output logic               empty,
    input  logic               pop,
    output logic [13:0]        year,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second,
    output logic               out_of_range
);

    // structure
    //   front: one register stage that range checks each beat and rebases it
    //          to seconds since 0001-01-01
    //   mid queue: QUEUE_DEPTH entries between front and back
    //   back: BACK_LAT stage pipeline, day split by reciprocal multiply,
    //         then the julian day to year, month and day steps in parallel
    //         with the hour, minute and second split
    //   result queue: RESULT_DEPTH entries; the back pipeline only takes a beat
    //         when a slot is reserved for it, so it never stalls
    // both depths must be at least 2

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int RCW = $clog2(RESULT_DEPTH + 1);
    localparam int IW  = $clog2(BACK_LAT + 1);
    localparam int SW  = $clog2(RESULT_DEPTH + BACK_LAT + 1);

    // front to mid queue
    logic          front_vld;
    es2dt_item_t   front_item;
    logic          mid_full;
    logic          mid_push;

    // mid queue to back
    es2dt_item_t   mid_item;
    logic          mid_empty;
    logic [QCW-1:0] mid_count;
    logic          issue;

    // back to result queue
    logic          back_vld;
    es2dt_result_t back_res;
    logic          res_push;
    logic          res_full;
    es2dt_result_t res_head;
    logic [RCW-1:0] res_count;
    logic          res_pop;

    // beats in flight in the back pipeline, for slot reservation
    logic [IW-1:0] inflight_reg, inflight_next;
    logic [SW-1:0] reserved;

    es2dt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .timestamp (timestamp),
        .full      (full),
        .out_vld   (front_vld),
        .out_item  (front_item),
        .out_full  (mid_full)
    );

    assign mid_push = front_vld && !mid_full;

    es2dt_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(es2dt_item_t))
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_item),
        .full    (mid_full),
        .rd_en   (issue),
        .rd_data (mid_item),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    // a beat enters the back pipeline only if the result queue has room for
    // it and for everything already in flight
    assign reserved = SW'(inflight_reg) + SW'(res_count);
    assign issue    = !mid_empty && (reserved < SW'(RESULT_DEPTH));

    always_comb
    begin
        inflight_next = inflight_reg;
        if (issue && !back_vld)
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (back_vld && !issue)
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    es2dt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (issue),
        .in_item (mid_item),
        .out_vld (back_vld),
        .out_res (back_res)
    );

    assign res_push = back_vld;
    assign res_pop  = pop && !empty;

    es2dt_fifo #(
        .DEPTH (RESULT_DEPTH),
        .WIDTH ($bits(es2dt_result_t))
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (res_pop),
        .rd_data (res_head),
        .empty   (empty),
        .count   (res_count)
    );

    // head of the result queue drives the result beat
    assign year         = res_head.year;
    assign month        = res_head.month;
    assign day          = res_head.day;
    assign hour         = res_head.hour;
    assign minute       = res_head.minute;
    assign second       = res_head.second;
    assign out_of_range = res_head.oor;

    // slot reservation must keep the result queue from overflowing
    `ES2DT_NEVER(a_res_overflow, res_push && res_full, "result queue written while full")
    `ES2DT_NEVER(a_reserve_bound, reserved > SW'(RESULT_DEPTH), "reserved slots exceed depth")
    `ES2DT_IMPLY(a_inflight_live, back_vld, inflight_reg != '0, "result beat with none in flight")
    `ES2DT_NEXT(a_front_load, push && !full, front_vld, "accepted beat lost in front stage")
    `ES2DT_IMPLY(a_mid_count, issue, mid_count != '0, "mid queue read with no entries")

endmodule

@@ rtl/core/es2dt_fifo.sv @@
module es2dt_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    output logic                       full,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

@@ rtl/core/es2dt_front.sv @@
module es2dt_front
    import es2dt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic signed [38:0] timestamp,
    output logic               full,
    output logic               out_vld,
    output es2dt_item_t        out_item,
    input  logic               out_full
);

    logic        vld_reg, vld_next;
    es2dt_item_t item_reg;
    es2dt_item_t item_next;
    logic        accept;

    assign full   = vld_reg && out_full;
    assign accept = push && !full;

    // range check and rebase to 0001-01-01
    always_comb
    begin
        item_next.oor = (timestamp < TS_MIN) || (timestamp > TS_MAX);
        item_next.ofs = item_next.oor ? '0 : 39'(timestamp) + TS_OFS;
        vld_next      = accept || (vld_reg && out_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

@@ rtl/core/es2dt_back.sv @@
module es2dt_back
    import es2dt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  es2dt_item_t   in_item,
    output logic          out_vld,
    output es2dt_result_t out_res
);

    logic [BACK_LAT-1:0] vld_reg;
    logic [BACK_LAT-2:0] oor_reg;

    // day split
    logic [31:0] v_reg [0:2];
    logic [6:0]  lo_reg [0:2];
    logic [21:0] qe1_reg, qe2_reg;
    logic [31:0] t2_reg;
    logic [21:0] days3_reg;
    logic [16:0] secs3_reg, secs4_reg;

    // date path
    logic [22:0] a_reg [4:5];
    logic [7:0]  b_reg [5:10];
    logic [17:0] c6_reg, c7_reg;
    logic [8:0]  dd_reg [7:10];
    logic [8:0]  e_reg [8:10];
    logic [3:0]  m9_reg, m10_reg;
    logic [10:0] t10_reg;

    // time of day path
    logic [10:0] s60_4_reg, s60_5_reg;
    logic [4:0]  hr_reg [5:10];
    logic [5:0]  sec_reg [5:10];
    logic [5:0]  min_reg [6:10];

    es2dt_result_t res_reg, res_next;

    logic [63:0] p1;
    logic [31:0] t2_next;
    logic [31:0] r3;
    logic [10:0] r3s;
    logic [21:0] days3_next;
    logic [9:0]  rc3;
    logic [22:0] a4_next;
    logic [34:0] p4;
    logic [24:0] xb;
    logic [50:0] pb;
    logic [16:0] s60x60;
    logic [16:0] sec5_full;
    logic [22:0] ph;
    logic [25:0] cb;
    logic [23:0] c6_full;
    logic [10:0] hx60;
    logic [10:0] min6_full;
    logic [19:0] xd;
    logic [40:0] pd;
    logic [19:0] tdd;
    logic [17:0] e8_full;
    logic [10:0] xm;
    logic [22:0] pm;
    logic [10:0] t10_next;
    logic [22:0] pq;
    logic [8:0]  day_full;
    logic        mge;
    logic [15:0] year_full;

    always_comb
    begin
        // floor of day count, one step of correction after the reciprocal
        p1         = {32'd0, v_reg[0]} * {32'd0, RCP_675};
        t2_next    = {10'd0, qe1_reg} * {22'd0, SPD_HI};
        r3         = v_reg[2] - t2_reg;
        r3s        = r3[10:0];
        if (r3s >= {1'b0, SPD_HI})
        begin
            days3_next = qe2_reg + 1'b1;
            rc3        = 10'(r3s - {1'b0, SPD_HI});
        end
        else
        begin
            days3_next = qe2_reg;
            rc3        = r3s[9:0];
        end

        a4_next    = {1'b0, days3_reg} + JDN_BIAS;
        p4         = {18'd0, secs3_reg} * {17'd0, RCP_60S};

        // century
        xb         = {a_reg[4], 2'b11};
        pb         = {26'd0, xb} * {25'd0, RCP_146097};
        s60x60     = {s60_4_reg, 6'd0} - {4'd0, s60_4_reg, 2'd0};
        sec5_full  = secs4_reg - s60x60;
        ph         = {12'd0, s60_4_reg} * {11'd0, RCP_60M};

        cb         = {8'd0, C_146097} * {18'd0, b_reg[5]};
        c6_full    = {1'b0, a_reg[5]} - cb[25:2];
        hx60       = {hr_reg[5], 6'd0} - {4'd0, hr_reg[5], 2'd0};
        min6_full  = s60_5_reg - hx60;

        // four-year cycles
        xd         = {c6_reg, 2'b11};
        pd         = {21'd0, xd} * {20'd0, RCP_1461};
        tdd        = {9'd0, C_1461} * {11'd0, dd_reg[7]};
        e8_full    = c7_reg - tdd[19:2];

        // month from march
        xm         = {e_reg[8], 2'b00} + {2'd0, e_reg[8]} + 11'd2;
        pm         = {12'd0, xm} * {11'd0, RCP_153};
        t10_next   = ({3'd0, C_153} * {7'd0, m9_reg}) + 11'd2;

        pq         = {12'd0, t10_reg} * {11'd0, RCP_5};
        day_full   = e_reg[10] - pq[22:14] + 9'd1;
        mge        = (m10_reg >= 4'd10);
        year_full  = ({8'd0, b_reg[10]} * 16'd100) + {7'd0, dd_reg[10]}
                   + {15'd0, mge} - YEAR_BIAS;

        if (oor_reg[BACK_LAT-2])
        begin
            res_next        = '0;
            res_next.oor    = 1'b1;
        end
        else
        begin
            res_next.year   = year_full[13:0];
            res_next.month  = mge ? m10_reg - 4'd9 : m10_reg + 4'd3;
            res_next.day    = day_full[4:0];
            res_next.hour   = hr_reg[10];
            res_next.minute = min_reg[10];
            res_next.second = sec_reg[10];
            res_next.oor    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg    <= {oor_reg[BACK_LAT-3:0], in_item.oor};

        v_reg[0]   <= in_item.ofs[38:7];
        lo_reg[0]  <= in_item.ofs[6:0];
        v_reg[1]   <= v_reg[0];
        lo_reg[1]  <= lo_reg[0];
        v_reg[2]   <= v_reg[1];
        lo_reg[2]  <= lo_reg[1];
        qe1_reg    <= p1[62:41];
        qe2_reg    <= qe1_reg;
        t2_reg     <= t2_next;

        days3_reg  <= days3_next;
        secs3_reg  <= {rc3, lo_reg[2]};

        a_reg[4]   <= a4_next;
        a_reg[5]   <= a_reg[4];
        secs4_reg  <= secs3_reg;
        s60_4_reg  <= p4[33:23];
        s60_5_reg  <= s60_4_reg;

        b_reg[5]   <= pb[50:43];
        hr_reg[5]  <= ph[21:17];
        sec_reg[5] <= sec5_full[5:0];

        c6_reg     <= c6_full[17:0];
        min_reg[6] <= min6_full[5:0];
        c7_reg     <= c6_reg;
        dd_reg[7]  <= pd[38:30];
        e_reg[8]   <= e8_full[8:0];
        m9_reg     <= pm[22:19];
        m10_reg    <= m9_reg;
        t10_reg    <= t10_next;

        for (int k = 6; k <= 10; k++)
        begin
            b_reg[k]   <= b_reg[k-1];
            hr_reg[k]  <= hr_reg[k-1];
            sec_reg[k] <= sec_reg[k-1];
        end
        for (int k = 7; k <= 10; k++)
        begin
            min_reg[k] <= min_reg[k-1];
        end
        for (int k = 8; k <= 10; k++)
        begin
            dd_reg[k]  <= dd_reg[k-1];
        end
        for (int k = 9; k <= 10; k++)
        begin
            e_reg[k]   <= e_reg[k-1];
        end

        res_reg    <= res_next;
    end

    assign out_vld = vld_reg[BACK_LAT-1];
    assign out_res = res_reg;

endmodule
